// ===== sv/bea_pkg.sv =====
// shared constants, types and the exp table for the ensemble average block
package bea_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EXP_TABLE_ADDR_BITS = 8;
  localparam int EXP_TABLE_DEPTH = 1 << EXP_TABLE_ADDR_BITS;
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  // register indexes on the config port
  localparam logic REG_BETA = 1'b0;
  localparam logic REG_MODE = 1'b1;

  localparam logic [31:0] BETA_RESET = 32'd16777216;

  typedef logic [31:0] exp_table_t [EXP_TABLE_DEPTH];

  // one classified level on its way from front to back
  typedef struct packed {
    logic [47:0]        weighted;
    logic signed [31:0] value;
    logic [31:0]        projection;
    logic               last;
  } entry_t;

  // 2^(-2^-k) in Q1.31, k = 1..12
  function automatic logic [31:0] half_power(input int k);
    logic [31:0] hp;
    case (k)
      1:       hp = 32'd1518500250;
      2:       hp = 32'd1805811301;
      3:       hp = 32'd1969251188;
      4:       hp = 32'd2056437387;
      5:       hp = 32'd2101467502;
      6:       hp = 32'd2124350982;
      7:       hp = 32'd2135885998;
      8:       hp = 32'd2141676973;
      9:       hp = 32'd2144578345;
      10:      hp = 32'd2146030505;
      11:      hp = 32'd2146756953;
      12:      hp = 32'd2147120270;
      default: hp = 32'd0;
    endcase
    return hp;
  endfunction

  // table of 2^(-i/2^B) in Q1.31, built once at elaboration
  function automatic exp_table_t build_exp_table();
    exp_table_t tbl;
    logic [63:0] t;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      t = 64'(ONE_Q31);
      for (int p = 0; p < EXP_TABLE_ADDR_BITS; p++) begin
        if (((i >> p) & 1) != 0) begin
          t = (t * 64'(half_power(EXP_TABLE_ADDR_BITS - p)) + 64'h4000_0000) >> 31;
        end
      end
      tbl[i] = t[31:0];
    end
    return tbl;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

// ===== sv/boltzmann_ensemble_average.sv =====
// top level of the boltzmann weighted ensemble average block
// Levels of a spectrum enter on the push side (push, full) and are taken one
// per cycle while full is low. A four stage front forms g*exp(-E*beta) from a
// 256 entry table, an eight entry queue decouples it from the back end, which
// multiplies, accumulates the partition and numerator sums with saturation,
// and on the level marked last runs a restoring divider one quotient bit per
// cycle. Levels stream at one per cycle while full is low; the 31 step
// division keeps the divider busy, and a further last level reaching the back
// end waits for it while levels keep filling the queue until full rises. The
// divider skips its run state when the partition sum is zero or the ratio
// saturates, loading the quotient directly. The result waits on
// the pop side (empty, pop); while it is not taken a following division
// result waits in the divider and the back end stalls, so full eventually
// rises. Reset clears both sums, the queue and the result register, and sets
// inverse temperature to 1.0 and plain mode. Configuration goes over the
// APB-style port: offset 0 inverse temperature, offset 4 sampled mode; the
// user must write them only while the block is idle; nothing enforces it.
module boltzmann_ensemble_average import bea_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] level_energy,
  input  logic [15:0]        level_degeneracy,
  input  logic signed [31:0] property_value,
  input  logic [31:0]        projection_weight,
  input  logic               last_level,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] average_value,
  output logic               zero_partition
);

  logic [31:0] inverse_temperature;
  logic        sampled_mode;
  logic        accept;
  logic        f_valid;
  entry_t      f_entry;
  logic        q_pop;
  logic        q_empty;
  entry_t      q_head;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_temperature <= BETA_RESET;
      sampled_mode        <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_BETA: inverse_temperature <= pwdata;
        REG_MODE: sampled_mode        <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {31'd0, sampled_mode} : inverse_temperature;

  // input transfer
  assign accept = push && !full;

  bea_front u_front (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .beta              (inverse_temperature),
    .level_energy      (level_energy),
    .level_degeneracy  (level_degeneracy),
    .property_value    (property_value),
    .projection_weight (projection_weight),
    .last_level        (last_level),
    .out_valid         (f_valid),
    .out_entry         (f_entry)
  );

  bea_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .reserve  (accept),
    .full     (full),
    .wr_valid (f_valid),
    .wr_entry (f_entry),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  bea_back u_back (
    .clk            (clk),
    .rst            (rst),
    .sampled_mode   (sampled_mode),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .average_value  (average_value),
    .zero_partition (zero_partition)
  );

endmodule

// ===== sv/bea_front.sv =====
// front pipeline: forms the boltzmann weight times degeneracy for each level
module bea_front import bea_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [31:0]        beta,
  input  logic signed [31:0] level_energy,
  input  logic [15:0]        level_degeneracy,
  input  logic signed [31:0] property_value,
  input  logic [31:0]        projection_weight,
  input  logic               last_level,
  output logic               out_valid,
  output entry_t             out_entry
);

  localparam int A_W = FRAC_BITS + 7;
  localparam int Y_W = A_W + 31;
  localparam int YS_W = A_W + 1;
  localparam int N_W = YS_W - FRAC_BITS + 1;
  localparam logic [A_W-1:0] A_CAP = A_W'(64) << FRAC_BITS;
  localparam int SH_DN = (FRAC_BITS > EXP_TABLE_ADDR_BITS) ?
                         FRAC_BITS - EXP_TABLE_ADDR_BITS : 0;
  localparam int SH_UP = (EXP_TABLE_ADDR_BITS > FRAC_BITS) ?
                         EXP_TABLE_ADDR_BITS - FRAC_BITS : 0;
  localparam int IDX_T_W = FRAC_BITS + SH_UP + 1;
  localparam logic [IDX_T_W-1:0] IDX_RND = (SH_DN > 0) ? IDX_T_W'(1) << (SH_DN - 1) : '0;

  typedef struct packed {
    logic [15:0]        degen;
    logic signed [31:0] value;
    logic [31:0]        projection;
    logic               last;
  } side_t;

  logic [3:0] valid;
  side_t side1, side2, side3;
  logic signed [63:0] prod;
  logic              unity2;
  logic [Y_W-1:0]    y_raw;
  logic [31:0]       weight;

  logic signed [64:0] prod_full;
  logic [63:0]        a_wide;
  logic [A_W-1:0]     a_cap;
  logic [Y_W:0]       y_sum;
  logic [YS_W-1:0]    y_val;
  logic [N_W-1:0]     n_full;
  logic [IDX_T_W-1:0] idx_t;
  logic [EXP_TABLE_ADDR_BITS-1:0] idx;
  logic [N_W-1:0]     n_adj;
  logic [31:0]        weight_next;

  // stage one: energy times inverse temperature
  assign prod_full = level_energy * $signed({1'b0, beta});

  // stage two: round, cap, scale by log2(e)
  assign a_wide = (64'(prod) + 64'd8388608) >> 24;
  assign a_cap  = (a_wide > 64'(A_CAP)) ? A_CAP : a_wide[A_W-1:0];

  // stage three: split into shift and table index
  always_comb begin
    y_sum  = {1'b0, y_raw} + (Y_W+1)'(64'd536870912);
    y_val  = y_sum[YS_W+29:30];
    n_full = N_W'(y_val >> FRAC_BITS);
    idx_t  = ((IDX_T_W'(y_val[FRAC_BITS-1:0]) + IDX_RND) >> SH_DN) << SH_UP;
    idx    = idx_t[EXP_TABLE_ADDR_BITS-1:0];
    n_adj  = n_full + N_W'(idx_t[EXP_TABLE_ADDR_BITS]);
    if (unity2) begin
      weight_next = ONE_Q31;
    end else if (n_adj >= N_W'(32)) begin
      weight_next = '0;
    end else begin
      weight_next = EXP_TABLE[idx] >> n_adj[4:0];
    end
  end

  // valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], accept};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    prod   <= prod_full[63:0];
    side1  <= '{level_degeneracy, property_value, projection_weight, last_level};
    unity2 <= (prod <= 64'sd0);
    y_raw  <= a_cap * LOG2E_Q30;
    side2  <= side1;
    weight <= weight_next;
    side3  <= side2;
    out_entry.weighted   <= side3.degen * weight;
    out_entry.value      <= side3.value;
    out_entry.projection <= side3.projection;
    out_entry.last       <= side3.last;
  end

  assign out_valid = valid[3];

endmodule

// ===== sv/bea_queue.sv =====
// short queue between front and back with credit for items still in the front
module bea_queue import bea_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   reserve,
  output logic   full,
  input  logic   wr_valid,
  input  entry_t wr_entry,
  input  logic   pop,
  output logic   empty,
  output entry_t head
);

  entry_t mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic [QUEUE_PTR_W:0]   credit;

  assign full  = (credit == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_valid) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // pointers, fill count and credit
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      credit <= '0;
    end else begin
      if (wr_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count  <= count + (QUEUE_PTR_W+1)'(wr_valid) - (QUEUE_PTR_W+1)'(pop);
      credit <= credit + (QUEUE_PTR_W+1)'(reserve) - (QUEUE_PTR_W+1)'(pop);
    end
  end

endmodule

// ===== sv/bea_back.sv =====
// back end: products, saturating sums, ratio divider and result register
module bea_back import bea_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               sampled_mode,
  input  logic               q_empty,
  input  entry_t             q_head,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] average_value,
  output logic               zero_partition
);

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_HOLD = 3'b100
  } div_state_t;

  localparam logic signed [64:0] N_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] N_MIN = -65'sh0_7FFF_FFFF_FFFF_FFFF;

  // product stage
  logic        p_valid;
  logic        p_last;
  logic        p_neg;
  logic [47:0] p_x;
  logic [63:0] p_zh, p_zl, p_nh;
  logic [47:0] p_nl;

  logic [63:0]        zsum;
  logic signed [63:0] nsum;

  div_state_t         state;
  logic [63:0]        den;
  logic [63:0]        rem;
  logic [31:0]        quo;
  logic               neg;
  logic               zflag;
  logic [4:0]         step;

  logic               out_valid;

  logic        adv;
  logic [31:0] vmag;
  logic [63:0] zterm;
  logic [48:0] term;
  logic [64:0] zadd;
  logic [63:0] z_next;
  logic signed [64:0] nadd;
  logic signed [63:0] n_next;
  logic [63:0] nmag_next;
  logic [64:0] rem_sh;
  logic        take;
  logic [63:0] rem_step;
  logic [31:0] res;

  assign adv   = !(p_valid && p_last && (state != DIV_IDLE));
  assign q_pop = adv && !q_empty;
  assign vmag  = q_head.value[31] ? 32'(-q_head.value) : q_head.value;

  // level terms and saturating accumulation
  always_comb begin
    zterm = sampled_mode ? ((p_zh + (p_zl >> 16)) >> 16) : 64'(p_x);
    term  = 49'((p_nh + 64'(p_nl >> 16)) >> 15);
    zadd  = {1'b0, zsum} + {1'b0, zterm};
    z_next = zadd[64] ? '1 : zadd[63:0];
    if (p_neg) begin
      nadd = 65'(nsum) - $signed({16'd0, term});
      n_next = (nadd < N_MIN) ? N_MIN[63:0] : nadd[63:0];
    end else begin
      nadd = 65'(nsum) + $signed({16'd0, term});
      n_next = (nadd > N_MAX) ? N_MAX[63:0] : nadd[63:0];
    end
    nmag_next = n_next[63] ? 64'(-n_next) : 64'(n_next);
  end

  // one restoring division step, and the signed result with saturation
  always_comb begin
    rem_sh   = {rem, 1'b0};
    take     = rem_sh[64] || (rem_sh[63:0] >= den);
    rem_step = take ? rem_sh[63:0] - den : rem_sh[63:0];
    if (neg) begin
      res = 32'd0 - quo;
    end else begin
      res = quo[31] ? 32'h7FFF_FFFF : quo;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_last <= q_head.last;
      p_neg  <= q_head.value[31];
      p_x    <= q_head.weighted;
      p_zh   <= q_head.weighted * q_head.projection[31:16];
      p_zl   <= q_head.weighted * q_head.projection[15:0];
      p_nh   <= vmag * q_head.weighted[47:16];
      p_nl   <= vmag * q_head.weighted[15:0];
    end
  end

  // sums, cleared after each last level
  always_ff @(posedge clk) begin
    if (rst) begin
      zsum <= '0;
      nsum <= '0;
    end else if (adv && p_valid) begin
      if (p_last) begin
        zsum <= '0;
        nsum <= '0;
      end else begin
        zsum <= z_next;
        nsum <= n_next;
      end
    end
  end

  // ratio divider sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      case (state)
        DIV_IDLE: begin
          if (adv && p_valid && p_last) begin
            if (z_next == '0 || nmag_next >= z_next) begin
              state <= DIV_HOLD;
            end else begin
              state <= DIV_RUN;
            end
          end
        end
        DIV_RUN: begin
          if (step == 5'd30) begin
            state <= DIV_HOLD;
          end
        end
        DIV_HOLD: begin
          if (!out_valid || pop) begin
            state <= DIV_IDLE;
          end
        end
        default: state <= DIV_IDLE;
      endcase
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        den   <= z_next;
        rem   <= nmag_next;
        neg   <= n_next[63];
        zflag <= (z_next == '0);
        step  <= '0;
        if (z_next == '0) begin
          quo <= '0;
        end else if (nmag_next >= z_next) begin
          quo <= ONE_Q31;
        end else begin
          quo <= '0;
        end
      end
      DIV_RUN: begin
        rem  <= rem_step;
        quo  <= {quo[30:0], take};
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == DIV_HOLD && (!out_valid || pop)) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == DIV_HOLD && (!out_valid || pop)) begin
      average_value  <= zflag ? 32'sd0 : $signed(res);
      zero_partition <= zflag;
    end
  end

  assign empty = !out_valid;

endmodule

// ===== test/boltzmann_ensemble_average_test.sv =====
// testbench for the boltzmann ensemble average block: directed table, random spectra, predictor
`timescale 1ns / 100ps

module boltzmann_ensemble_average_test;
  import bea_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 119;
  localparam longint NUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  // idling schemes
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic signed [31:0] energy;
    logic [15:0]        degen;
    logic signed [31:0] value;
    logic [31:0]        proj;
    logic               last;
  } level_t;

  typedef struct {
    logic signed [31:0] average;
    logic               zero_z;
  } average_t;

  typedef struct {
    logic [31:0]        beta;
    logic               mode;
    level_t             lv;
    bit                 typed;
    logic signed [31:0] avg;
    logic               zp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic signed [31:0] level_energy = '0;
  logic [15:0] level_degeneracy = '0;
  logic signed [31:0] property_value = '0;
  logic [31:0] projection_weight = '0;
  logic last_level = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [31:0] average_value;
  logic zero_partition;

  // predictor state and configuration copy
  logic [31:0] beta_cfg = BETA_RESET;
  logic        mode_cfg = 1'b0;
  logic [63:0] z_sum = '0;
  longint      n_sum = 0;

  average_t   pending_averages[$];
  idle_mode_t idle_mode = IDLE_NONE;
  int         error_count = 0;
  int         quiet_cycles = 0;

  // 2^(-2^-k) in Q1.31
  logic [31:0] half_pow [1:8] = '{32'd1518500250, 32'd1805811301, 32'd1969251188,
    32'd2056437387, 32'd2101467502, 32'd2124350982, 32'd2135885998, 32'd2141676973};

  boltzmann_ensemble_average DUT (.*);

  always #10 clk = ~clk;

  // fixed point exp(-E*beta) in Q1.31
  function automatic logic [63:0] boltz_factor(input logic signed [31:0] e);
    longint prod;
    logic [63:0] a, y, n, frac, idx, t;
    prod = longint'(e) * longint'({32'd0, beta_cfg});
    if (prod <= 0) return 64'h8000_0000;
    a = (64'(prod) + (64'd1 << 23)) >> 24;
    if (a > (64'd64 << FRAC_BITS)) a = 64'd64 << FRAC_BITS;
    y = (a * 64'(LOG2E_Q30) + (64'd1 << 29)) >> 30;
    n = y >> FRAC_BITS;
    frac = y & ((64'd1 << FRAC_BITS) - 1);
    idx = (frac + (64'd1 << (FRAC_BITS - EXP_TABLE_ADDR_BITS - 1)))
          >> (FRAC_BITS - EXP_TABLE_ADDR_BITS);
    if (idx >= (64'd1 << EXP_TABLE_ADDR_BITS)) begin
      idx = 0;
      n = n + 1;
    end
    if (n >= 32) return 64'd0;
    t = 64'h8000_0000;
    for (int p = 0; p < EXP_TABLE_ADDR_BITS; p++) begin
      if (idx[p]) t = (t * 64'(half_pow[EXP_TABLE_ADDR_BITS - p]) + 64'h4000_0000) >> 31;
    end
    return t >> n;
  endfunction

  // restoring division, Q31 quotient of mag/den
  function automatic logic [31:0] ratio_q31(input logic [63:0] mag, input logic [63:0] den);
    logic [63:0] r, q;
    logic carry;
    if (mag / den >= 1) return 32'h8000_0000;
    r = mag;
    q = 0;
    for (int i = 0; i < 31; i++) begin
      carry = r[63];
      r = r << 1;
      q = q << 1;
      if (carry || r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q[31:0];
  endfunction

  // accumulate one level, return 1 with the average on a last level
  function automatic bit accumulate_level(input level_t lv, output average_t res);
    logic [63:0] x, zterm, vmag, term, nmag, q;
    x = 64'(lv.degen) * boltz_factor(lv.energy);
    if (mode_cfg) zterm = ((x * 64'(lv.proj[31:16])) + ((x * 64'(lv.proj[15:0])) >> 16)) >> 16;
    else zterm = x;
    if (z_sum > ~64'd0 - zterm) z_sum = ~64'd0;
    else z_sum = z_sum + zterm;
    vmag = (lv.value < 0) ? 64'(-longint'(lv.value)) : 64'(longint'(lv.value));
    term = ((vmag * (x >> 16)) + ((vmag * (x & 64'hFFFF)) >> 16)) >> 15;
    if (lv.value < 0) begin
      if (n_sum < -NUM_MAX + longint'(term)) n_sum = -NUM_MAX;
      else n_sum = n_sum - longint'(term);
    end else begin
      if (n_sum > NUM_MAX - longint'(term)) n_sum = NUM_MAX;
      else n_sum = n_sum + longint'(term);
    end
    res.average = '0;
    res.zero_z = 1'b0;
    if (!lv.last) return 1'b0;
    if (z_sum == 0) begin
      res.zero_z = 1'b1;
    end else begin
      nmag = (n_sum < 0) ? 64'(-n_sum) : 64'(n_sum);
      q = 64'(ratio_q31(nmag, z_sum));
      if (n_sum < 0) res.average = 32'(64'd0 - q);
      else res.average = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    z_sum = '0;
    n_sum = 0;
    return 1'b1;
  endfunction

  function automatic bit idle_roll(input bit sender_side);
    int pct;
    case (idle_mode)
      IDLE_SENDER:   pct = sender_side ? 52 : 0;
      IDLE_RECEIVER: pct = sender_side ? 0 : 52;
      IDLE_BOTH:     pct = 27;
      default:       pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  // config write, setup then access cycle, called at a falling edge
  task automatic write_reg(input logic idx, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_BETA) beta_cfg = data;
    else mode_cfg = data[0];
  endtask

  // wait for all averages, then let the pipeline settle
  task automatic drain();
    push <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input logic [31:0] beta, input logic mode);
    drain();
    write_reg(REG_BETA, beta);
    write_reg(REG_MODE, {31'd0, mode});
  endtask

  // one level transfer; typed expectation replaces the predicted one
  task automatic send_level(input level_t lv, input bit typed, input average_t typed_avg);
    average_t res;
    while (idle_roll(1'b1)) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    level_energy <= lv.energy;
    level_degeneracy <= lv.degen;
    property_value <= lv.value;
    projection_weight <= lv.proj;
    last_level <= lv.last;
    do @(posedge clk); while (full);
    if (accumulate_level(lv, res)) begin
      if (typed) res = typed_avg;
      pending_averages.insert(pending_averages.size(), res);
    end
    @(negedge clk);
  endtask

  function automatic level_t random_level(input bit force_last);
    level_t lv;
    case ($urandom_range(0, 7))
      0:       lv.energy = $urandom;
      1:       lv.energy = -$signed({1'b0, 31'($urandom_range(0, 32'h0010_0000))});
      default: lv.energy = $urandom_range(0, 32'h0006_0000);
    endcase
    lv.degen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    lv.value = $urandom;
    lv.proj = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 255)) : $urandom;
    lv.last = force_last || ($urandom_range(0, 5) == 0);
    return lv;
  endfunction

  // result side stalls
  always @(negedge clk) begin
    pop <= !idle_roll(1'b0);
  end

  // result check and watchdog
  always @(posedge clk) begin
    average_t exp_avg;
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (pop && !empty) begin
        if (pending_averages.size() == 0) begin
          $display("%0t: unexpected result avg=%h zp=%b", $time, average_value,
                   zero_partition);
          error_count++;
        end else begin
          exp_avg = pending_averages.pop_front();
          if (average_value !== exp_avg.average) begin
            $display("%0t: average_value expected %h actual %h", $time, exp_avg.average,
                     average_value);
            error_count++;
          end
          if (zero_partition !== exp_avg.zero_z) begin
            $display("%0t: zero_partition expected %b actual %b", $time, exp_avg.zero_z,
                     zero_partition);
            error_count++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** boltzmann_ensemble_average: FAILED **");
        $finish;
      end
    end
  end

  // directed table of levels; typed rows can be read off directly
  row_t directed[] = '{
    '{BETA_RESET, 1'b0, '{32'sh0, 16'd1, 32'sh10000, 32'h0, 1'b1}, 1, 32'sh10000, 1'b0},
    '{BETA_RESET, 1'b0, '{-32'sd1, 16'd5, -32'sd196608, 32'h0, 1'b1}, 1,
      -32'sd196608, 1'b0},
    '{BETA_RESET, 1'b0, '{32'sh10000, 16'd0, 32'sh7000, 32'h0, 1'b1}, 1, 32'sh0, 1'b1},
    '{BETA_RESET, 1'b0, '{32'sh7FFF_FFFF, 16'hFFFF, 32'sh1, 32'h0, 1'b1}, 1, 32'sh0, 1'b1},
    '{BETA_RESET, 1'b0, '{32'sh0, 16'd1, 32'sh7FFF_FFFF, 32'h0, 1'b1}, 1,
      32'sh7FFF_FFFF, 1'b0},
    '{BETA_RESET, 1'b0, '{32'sh0, 16'd1, 32'sh8000_0000, 32'h0, 1'b1}, 1,
      32'sh8000_0000, 1'b0},
    '{BETA_RESET, 1'b0, '{32'sh8000, 16'd3, 32'sh20000, 32'h0, 1'b0}, 0, 32'sh0, 1'b0},
    '{BETA_RESET, 1'b0, '{32'sh30000, 16'hFFFF, -32'sh5000, 32'hFFFF_FFFF, 1'b0}, 0,
      32'sh0, 1'b0},
    '{BETA_RESET, 1'b0, '{32'sh10000, 16'd1, 32'sh7FFF_FFFF, 32'h0, 1'b1}, 0, 32'sh0, 1'b0},
    '{32'h0, 1'b0, '{32'sh7FFF_FFFF, 16'd2, 32'sh12345, 32'h0, 1'b1}, 1, 32'sh12345, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, '{32'sh1, 16'd1, 32'sh10000, 32'h0, 1'b1}, 0, 32'sh0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, '{32'sh7FFF_FFFF, 16'd1, 32'sh1, 32'h0, 1'b0}, 0, 32'sh0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, '{32'sh0, 16'd1, 32'sh10000, 32'h0, 1'b1}, 0, 32'sh0, 1'b0},
    '{BETA_RESET, 1'b1, '{32'sh0, 16'd1, 32'sh10000, 32'h0, 1'b1}, 1, 32'sh0, 1'b1},
    '{BETA_RESET, 1'b1, '{32'sh0, 16'hFFFF, 32'sh40000, 32'hFFFF_FFFF, 1'b1}, 0,
      32'sh0, 1'b0},
    '{BETA_RESET, 1'b1, '{32'sh0, 16'd1, 32'sh7FFF_FFFF, 32'h1, 1'b1}, 0, 32'sh0, 1'b0},
    '{BETA_RESET, 1'b1, '{32'sh40_0000, 16'd100, -32'sd5, 32'h8000_0000, 1'b1}, 0,
      32'sh0, 1'b0}
  };

  // main stimulus
  initial begin
    average_t typed_avg;
    logic [31:0] beta;
    logic mode;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    configure(BETA_RESET, 1'b0);

    // directed part, reconfigured between spectra where the row asks
    foreach (directed[i]) begin
      if (directed[i].beta != beta_cfg || directed[i].mode != mode_cfg)
        configure(directed[i].beta, directed[i].mode);
      typed_avg.average = directed[i].avg;
      typed_avg.zero_z = directed[i].zp;
      send_level(directed[i].lv, directed[i].typed, typed_avg);
    end

    // random spectra over several settings and idling schemes
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       beta = BETA_RESET;
        1:       beta = 32'h0;
        2:       beta = 32'hFFFF_FFFF;
        3:       beta = $urandom;
        default: beta = $urandom_range(32'h0010_0000, 32'h0400_0000);
      endcase
      mode = (ph == 1) ? 1'b1 : (ph == 2) ? 1'b0 : 1'($urandom);
      configure(beta, mode);
      idle_mode = idle_mode_t'(ph % 4);
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_level(random_level(k == PHASE_ITEMS - 1), 0, typed_avg);
    end

    idle_mode = IDLE_NONE;
    drain();
    if (error_count == 0) begin
      $display("** boltzmann_ensemble_average: PASSED **");
    end else begin
      $display("** boltzmann_ensemble_average: FAILED **");
    end
    $finish;
  end

endmodule

// ===== boltzmann_ensemble_average.f =====
sv/bea_pkg.sv
sv/bea_front.sv
sv/bea_queue.sv
sv/bea_back.sv
sv/boltzmann_ensemble_average.sv
test/boltzmann_ensemble_average_test.sv
